@@ src/tcw_pkg.sv @@
// Shared types, constants and table helpers for the text console writer.
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0]  CH_NL       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_BS       = 8'h08;
  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  ATTR_RESET  = 8'h07;
  localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef logic [7:0] mod_tab_t [256];

  // Residue of every byte value for modulus m, built by a wrapping count.
  function automatic mod_tab_t mod_table(input int unsigned m);
    mod_tab_t    tab;
    int unsigned r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'(r);
      r = (r + 1 == m) ? 0 : r + 1;
    end
    return tab;
  endfunction

endpackage

@@ src/text_console_writer.sv @@
// Text console writer top level: command sequencer, cursor and scroll state.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready | tdata: char, row, col; tuser: cmd
//  m_axis    | m_axis_tvalid/m_axis_tready | tdata: cursor row, cursor col, cell
//  cfg       | cfg_valid_i/cfg_ready_o     | cfg_data_i: text attribute
//
// Put and set cursor steps: accept, then at most one RAM write.
// Read steps: accept, RAM read, then the registered word is loaded.
// A put that scrolls then blanks the bottom line through the single RAM write port
// while a row base pointer rotates, so no line is copied.
// Clear screen then blanks every cell, one cell write per cycle.
// After reset the store is blanked while s_axis_tready is low.
// A result stalled on m_axis holds the next command at its final cycle.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] char_code, [15:8] target_row, [23:16] target_col
  input  logic [tcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] cmd
  input  logic [tcw_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [27:12] cell_value, [31:28] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [7:0]                       cfg_data_i
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned AW = RW + CW;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam mod_tab_t ROW_MOD = mod_table(ROWS);
  localparam mod_tab_t COL_MOD = mod_table(COLUMNS);

  state_e        state_q, state_d;
  cmd_e          cmd_q;
  logic [7:0]    ch_q, tr_q, tc_q;
  logic [7:0]    attr_q;
  logic [RW-1:0] row_q, row_d, top_q, top_d, sw_row_q, sw_row_d;
  logic [CW-1:0] col_q, col_d, sw_col_q, sw_col_d;
  logic          sw_scroll_q, sw_scroll_d;
  logic          out_valid_q, out_load;
  logic [15:0]   out_cell_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data, rd_data;

  logic [RW-1:0] lrow, prow, rd_row, rd_col_row;
  logic [CW-1:0] rd_col;
  logic [RW:0]   psum;
  logic [CW:0]   tab_col;
  logic          sw_last;
  logic [31:0]   row_ext, col_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Logical row to physical row through the rotating base.
  assign rd_row = ROW_MOD[tr_q][RW-1:0];
  assign rd_col = COL_MOD[tc_q][CW-1:0];
  assign lrow   = (cmd_q == CMD_READ) ? rd_row : row_q;
  assign psum   = (RW+1)'(lrow) + (RW+1)'(top_q);
  assign prow   = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : psum[RW-1:0];
  assign rd_col_row = prow;

  assign tab_col = ((CW+1)'(col_q) + (CW+1)'(8)) & ~(CW+1)'(7);
  assign sw_last = (sw_col_q == COL_LAST) && (sw_scroll_q || (sw_row_q == ROW_LAST));

  always_comb begin
    logic wrap;
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    sw_row_d    = sw_row_q;
    sw_col_d    = sw_col_q;
    sw_scroll_d = sw_scroll_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = {attr_q, CH_SPACE};
    rd_en       = 1'b0;
    rd_addr     = {rd_col_row, rd_col};
    out_load    = 1'b0;
    wrap        = 1'b0;

    if (state_q == ST_INIT || state_q == ST_SWEEP) begin
      if (sw_col_q == COL_LAST) begin
        sw_col_d = '0;
        sw_row_d = sw_row_q + RW'(1);
      end else begin
        sw_col_d = sw_col_q + CW'(1);
      end
    end

    case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = {sw_row_q, sw_col_q};
        wr_data = BLANK_RESET;
        if (sw_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            case (ch_q)
              CH_NL: begin
                col_d = '0;
                wrap  = 1'b1;
              end
              CH_CR: col_d = '0;
              CH_BS: begin
                if (col_q != '0) begin
                  col_d   = col_q - CW'(1);
                  wr_en   = 1'b1;
                  wr_addr = {prow, col_q - CW'(1)};
                end
              end
              CH_TAB: begin
                if (tab_col >= (CW+1)'(COLUMNS)) begin
                  col_d = '0;
                  wrap  = 1'b1;
                end else begin
                  col_d = tab_col[CW-1:0];
                end
              end
              default: begin
                wr_en   = 1'b1;
                wr_addr = {prow, col_q};
                wr_data = {attr_q, ch_q};
                if (col_q == COL_LAST) begin
                  col_d = '0;
                  wrap  = 1'b1;
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
            endcase
            if (wrap && row_q == ROW_LAST) begin
              // scroll: blank the top physical row, which becomes the bottom line
              sw_scroll_d = 1'b1;
              sw_col_d    = '0;
              state_d     = ST_SWEEP;
            end else begin
              if (wrap) begin
                row_d = row_q + RW'(1);
              end
              out_load = !out_valid_q || m_axis_tready;
              state_d  = out_load ? ST_IDLE : ST_DONE;
            end
          end
          CMD_CLEAR: begin
            row_d       = '0;
            col_d       = '0;
            top_d       = '0;
            sw_scroll_d = 1'b0;
            sw_row_d    = '0;
            sw_col_d    = '0;
            state_d     = ST_SWEEP;
          end
          CMD_SET: begin
            row_d    = rd_row;
            col_d    = rd_col;
            out_load = !out_valid_q || m_axis_tready;
            state_d  = out_load ? ST_IDLE : ST_DONE;
          end
          default: begin
            rd_en   = 1'b1;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = {sw_scroll_q ? top_q : sw_row_q, sw_col_q};
        if (sw_last) begin
          if (sw_scroll_q) begin
            top_d = (top_q == ROW_LAST) ? '0 : top_q + RW'(1);
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_load = !out_valid_q || m_axis_tready;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign row_ext = 32'(row_d);
  assign col_ext = 32'(col_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      sw_scroll_q <= 1'b0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_PUT;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
      sw_scroll_q <= sw_scroll_d;
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_q <= cmd_e'(s_axis_tuser);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ch_q <= s_axis_tdata[7:0];
      tr_q <= s_axis_tdata[15:8];
      tc_q <= s_axis_tdata[23:16];
    end
    if (out_load) begin
      out_row_q  <= row_ext[4:0];
      out_col_q  <= col_ext[6:0];
      out_cell_q <= (cmd_q == CMD_READ) ? rd_data : 16'h0000;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_cell_q, out_col_q, out_row_q};

  tcw_cell_ram #(
    .AW(AW)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

@@ src/tcw_cell_ram.sv @@
// Cell store: one write port, one read port with registered read data.
module tcw_cell_ram #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o
);

  logic [15:0] mem [2**AW];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one command at a time: a new beat is never taken right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  // cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ROWS > 32) || (32'(m_axis_tdata[4:0]) < ROWS))
    else $error("cursor row out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (COLUMNS > 128) || (32'(m_axis_tdata[11:5]) < COLUMNS))
    else $error("cursor column out of range");

  // the input is not ready at the clock where reset is first seen released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready during reset blanking");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);

@@ verif/tcw_shadow_check.sv @@
// Shadow screen for the text console writer: tracks every beat, predicts results, compares.
`timescale 1ns / 1ps

module tcw_shadow_check
  import tcw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  // [7:0] char_code, [15:8] target_row, [23:16] target_col
  input  logic [IN_DATA_W-1:0]  in_data_i,
  // [1:0] cmd
  input  logic [IN_USER_W-1:0]  in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  // [4:0] cursor_row, [11:5] cursor_col, [27:12] cell_value, [31:28] zero
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  attr_valid_i,
  input  logic                  attr_ready_i,
  input  logic [7:0]            attr_data_i,
  output int                    errors_o,
  output int                    outstanding_o
);

  localparam int unsigned NCOL  = COLUMNS_DEF;
  localparam int unsigned NROW  = ROWS_DEF;
  localparam int unsigned NCELL = NCOL * NROW;

  // Same layout as the result beat, lowest field last.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] cell_val;
    logic [6:0]  col;
    logic [4:0]  row;
  } console_report_t;

  logic [15:0]     screen [NCELL];
  int unsigned     cur_row;
  int unsigned     cur_col;
  logic [7:0]      attr;
  console_report_t expected_reports [$];
  int              errors  = 0;
  int              waiting = 0;

  assign errors_o      = errors;
  assign outstanding_o = waiting;

  function automatic logic [15:0] blank_cell();
    return {attr, CH_SPACE};
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < NCELL - NCOL; i++) screen[i] = screen[i + NCOL];
    for (int i = NCELL - NCOL; i < NCELL; i++) screen[i] = blank_cell();
    if (cur_row > 0) cur_row--;
  endfunction

  function automatic console_report_t console_step(input cmd_e op, input logic [7:0] ch,
                                                   input logic [7:0] tr, input logic [7:0] tc);
    console_report_t rep;
    rep = '0;
    case (op)
      CMD_PUT: begin
        if (ch == CH_NL) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row * NCOL + cur_col] = blank_cell();
          end
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col + 8) & ~32'd7;
          if (cur_col >= NCOL) begin
            cur_col = 0;
            cur_row++;
          end
        end else begin
          screen[cur_row * NCOL + cur_col] = {attr, ch};
          cur_col++;
          if (cur_col >= NCOL) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= NROW) scroll_up();
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCELL; i++) screen[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      CMD_SET: begin
        cur_row = tr % NROW;
        cur_col = tc % NCOL;
      end
      default: begin
        rep.cell_val = screen[(tr % NROW) * NCOL + (tc % NCOL)];
      end
    endcase
    rep.row = 5'(cur_row);
    rep.col = 7'(cur_col);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_report_t got;
    console_report_t want;
    if (!rst_ni) begin
      attr = ATTR_RESET;
      for (int i = 0; i < NCELL; i++) screen[i] = BLANK_RESET;
      cur_row = 0;
      cur_col = 0;
      expected_reports.delete();
      waiting = 0;
    end else begin
      // Compare before predicting so a stray beat never matches this edge's command.
      if (out_valid_i && out_ready_i) begin
        got = console_report_t'(out_data_i);
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %h", $time, out_data_i);
        end else begin
          want = expected_reports.pop_front();
          if (got.row != want.row) begin
            errors++;
            $display("%0t: cursor_row expected %0d got %0d", $time, want.row, got.row);
          end
          if (got.col != want.col) begin
            errors++;
            $display("%0t: cursor_col expected %0d got %0d", $time, want.col, got.col);
          end
          if (got.cell_val != want.cell_val) begin
            errors++;
            $display("%0t: cell_value expected %h got %h", $time, want.cell_val,
                     got.cell_val);
          end
          if (got.pad != want.pad) begin
            errors++;
            $display("%0t: pad bits expected %h got %h", $time, want.pad, got.pad);
          end
        end
      end
      if (attr_valid_i && attr_ready_i) attr = attr_data_i;
      if (in_valid_i && in_ready_i) begin
        expected_reports.push_back(console_step(cmd_e'(in_user_i), in_data_i[7:0],
                                                in_data_i[15:8], in_data_i[23:16]));
      end
      waiting = expected_reports.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the text console writer: clock, reset, stimulus, watchdog, verdict.
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = COLUMNS_DEF + 32;
  localparam int unsigned PHASE_ITEMS    = 180;
  localparam logic [7:0]  LAST_ROW       = 8'(ROWS_DEF - 1);
  localparam logic [7:0]  LAST_COL       = 8'(COLUMNS_DEF - 1);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [7:0]            cfg_data_i;

  int          mismatches;
  int          in_flight;
  int unsigned gap_odds     = 0;
  int unsigned stall_odds   = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  text_console_writer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  tcw_shadow_check shadow (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .attr_valid_i (cfg_valid_i),
    .attr_ready_i (cfg_ready_o),
    .attr_data_i  (cfg_data_i),
    .errors_o     (mismatches),
    .outstanding_o(in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure in bursts.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command beat and hold it until accepted; valid stays high on return.
  task automatic issue(input cmd_e op, input logic [7:0] ch, input logic [7:0] tr,
                       input logic [7:0] tc);
    int unsigned gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {tc, tr, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop the command stream, wait for every result, then write the attribute.
  task automatic load_attribute(input logic [7:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic issue_random();
    int unsigned pick;
    cmd_e        op;
    logic [7:0]  ch;
    logic [7:0]  tr;
    logic [7:0]  tc;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    tr   = 8'($urandom_range(0, 255));
    tc   = 8'($urandom_range(0, 255));
    if (pick < 2) begin
      op = CMD_CLEAR;
    end else if (pick < 12) begin
      op = CMD_SET;
      // Park near the bottom right so puts soon wrap and scroll.
      if ($urandom_range(0, 1) == 1) begin
        tr = 8'($urandom_range(ROWS_DEF - 4, ROWS_DEF - 1));
        tc = 8'($urandom_range(COLUMNS_DEF - 12, COLUMNS_DEF - 1));
      end
    end else if (pick < 35) begin
      op = CMD_READ;
      if ($urandom_range(0, 2) != 0) begin
        tr = 8'($urandom_range(0, ROWS_DEF - 1));
        tc = 8'($urandom_range(0, COLUMNS_DEF - 1));
      end
    end else begin
      op = CMD_PUT;
      case ($urandom_range(0, 9))
        0: ch = CH_NL;
        1: ch = CH_CR;
        2: ch = CH_BS;
        3: ch = CH_TAB;
        4, 5: ;
        default: ch = 8'($urandom_range(8'h21, 8'h7E));
      endcase
    end
    issue(op, ch, tr, tc);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUT;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset contents, byte extremes, control characters, wraps and scrolls.
    issue(CMD_READ, 8'h00, 8'h00, 8'h00);
    issue(CMD_PUT, 8'h41, 8'hFF, 8'hFF);
    issue(CMD_PUT, 8'h00, 8'h00, 8'h00);
    issue(CMD_PUT, 8'hFF, 8'h00, 8'h00);
    issue(CMD_PUT, CH_BS, 8'h00, 8'h00);
    issue(CMD_READ, 8'h00, 8'h00, 8'h02);
    issue(CMD_PUT, CH_TAB, 8'h00, 8'h00);
    issue(CMD_PUT, CH_CR, 8'h00, 8'h00);
    issue(CMD_PUT, CH_BS, 8'h00, 8'h00);
    issue(CMD_PUT, CH_NL, 8'h00, 8'h00);
    issue(CMD_SET, 8'h00, 8'hFF, 8'hFF);
    issue(CMD_SET, 8'h00, LAST_ROW, LAST_COL);
    issue(CMD_PUT, 8'h7E, 8'h00, 8'h00);
    issue(CMD_READ, 8'h00, LAST_ROW - 8'd1, LAST_COL);
    issue(CMD_SET, 8'h00, LAST_ROW, LAST_COL - 8'd2);
    issue(CMD_PUT, CH_TAB, 8'h00, 8'h00);
    issue(CMD_SET, 8'h00, LAST_ROW, 8'h00);
    issue(CMD_PUT, CH_NL, 8'h00, 8'h00);
    issue(CMD_READ, 8'h00, 8'hFF, 8'hFF);
    issue(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    issue(CMD_READ, 8'h00, 8'h00, 8'h00);
    issue(CMD_READ, 8'h00, LAST_ROW, LAST_COL);

    // Random phases, one attribute each; the tail runs without idling.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: load_attribute(8'h00);
        2: load_attribute(8'hFF);
        3: load_attribute(8'($urandom_range(0, 255)));
        4: load_attribute(8'h1E);
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) begin
          if (phase == 4 && n >= 60) begin
            gap_odds   = 0;
            stall_odds = 0;
          end else begin
            gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
          end
        end
        issue_random();
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
